@@ rtl/tsnd_pkg.sv @@
package tsnd_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int OCT_W   = 4;
    localparam int DUR_W   = 16;
    localparam int TONE_W  = 14;
    localparam int PIT_W   = 16;
    localparam int DELAY_W = 18;
    localparam int BPM_W   = 16;

    // Shared divider widths
    localparam int DIV_NW = 21;
    localparam int DIV_DW = (DUR_W > BPM_W) ? DUR_W : BPM_W;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Work queue between parser and note engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Arithmetic constants
    localparam logic [DIV_NW-1:0] PIT_CLOCK  = DIV_NW'(1193180);
    localparam logic [DIV_NW-1:0] MS_PER_MIN = DIV_NW'(60000);
    localparam logic [BPM_W-1:0]  TEMPO_RST  = BPM_W'(120);
    localparam logic [DUR_W-1:0]  DUR_DEFAULT = DUR_W'(4);
    localparam logic [OCT_W-1:0]  OCT_DEFAULT = OCT_W'(4);
    localparam logic [DUR_W+3:0]  DUR_MAX = (DUR_W+4)'((64'd1 << DUR_W) - 64'd1);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;

    // One note handed from the parser to the note engine
    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic [DUR_W-1:0]  dur;
        logic              last_of_run;
        logic              end_of_tune;
    } note_job_t;

    // Divider request
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    // Base tone of a letter, zero for a rest
    function automatic logic [TONE_W-1:0] base_tone(input logic [CHAR_W-1:0] letter);
        logic [TONE_W-1:0] t;
        unique case (letter)
            CH_C:    t = TONE_W'(262);
            CH_D:    t = TONE_W'(294);
            CH_E:    t = TONE_W'(330);
            CH_F:    t = TONE_W'(349);
            CH_G:    t = TONE_W'(392);
            CH_A:    t = TONE_W'(440);
            CH_B:    t = TONE_W'(494);
            default: t = '0;
        endcase
        return t;
    endfunction

    // Shift the base tone by octave, at most five doublings
    function automatic logic [TONE_W-1:0] tone_of(input logic [CHAR_W-1:0] letter,
                                                  input logic [OCT_W-1:0] oct);
        logic [TONE_W-1:0] base;
        logic [OCT_W-1:0]  up;
        logic [2:0]        sh;
        logic [TONE_W-1:0] t;
        base = base_tone(letter);
        up   = oct - OCT_DEFAULT;
        if (oct > OCT_DEFAULT)
        begin
            sh = (up > OCT_W'(5)) ? 3'd5 : up[2:0];
            t  = base << sh;
        end
        else
        begin
            t = base >> (OCT_DEFAULT - oct);
        end
        return t;
    endfunction

endpackage

@@ rtl/tune_string_note_decoder_top.sv @@
// Tune string note decoder: one item per character in, one item per note out.
// Each note runs two chained 21-step bit-serial divides: timer divisor with tempo, then duration
// (skipped at zero duration); the engine takes no new note until the last is loaded for output.
// A byte that ends no note is taken each cycle; one that ends notes blocks input until they
// have all entered the queue, longer while the queue is full.
// Reset: asynchronous, active low; parser idle, queues empty, tempo set to 120 bpm.
module tune_string_note_decoder_top
    import tsnd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               last_char,
    output logic               empty,
    input  logic               pop,
    output logic [TONE_W-1:0]  tone_hz,
    output logic [PIT_W-1:0]   pit_divisor,
    output logic [DELAY_W-1:0] note_ms,
    output logic               is_rest,
    output logic               bad_duration,
    output logic               last_of_run,
    output logic               end_of_tune,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BPM_W-1:0]   tempo_bpm
);

    logic [BPM_W-1:0] tempo_reg;
    logic             fe_valid;
    note_job_t        fe_job;
    logic             q_full;
    logic             q_pop;
    note_job_t        q_job;
    logic             q_empty;

    assign cfg_ready = 1'b1;

    // Hold tempo register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg <= TEMPO_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tempo_reg <= tempo_bpm;
        end
    end

    // Parser
    tsnd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .last_char (last_char),
        .job_valid (fe_valid),
        .job       (fe_job),
        .job_full  (q_full)
    );

    // Note queue
    tsnd_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_valid),
        .wr_data (fe_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_job),
        .q_empty (q_empty)
    );

    // Note engine
    tsnd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tempo        (tempo_reg),
        .job_empty    (q_empty),
        .job          (q_job),
        .job_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .tone_hz      (tone_hz),
        .pit_divisor  (pit_divisor),
        .note_ms      (note_ms),
        .is_rest      (is_rest),
        .bad_duration (bad_duration),
        .last_of_run  (last_of_run),
        .end_of_tune  (end_of_tune)
    );

endmodule

@@ rtl/tsnd_div.sv @@
module tsnd_div
    import tsnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    logic [DIV_NW-1:0] dvd_reg, dvd_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dsr_reg, dsr_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   dsr_ext;
    logic              ge;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[DIV_NW-1]};
        dsr_ext   = {1'b0, dsr_reg};
        ge        = rem_sh >= dsr_ext;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            rem_next = ge ? DIV_DW'(rem_sh - dsr_ext) : rem_sh[DIV_DW-1:0];
            cnt_next = cnt_reg + DIV_CW'(1);
            if (cnt_reg == DIV_CW'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/tsnd_fifo.sv @@
module tsnd_fifo
    import tsnd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  note_job_t wr_data,
    output logic      q_full,
    input  logic      rd_en,
    output note_job_t rd_data,
    output logic      q_empty
);

    note_job_t           mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    assign q_full  = cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign q_empty = cnt_reg == '0;
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + (QUEUE_AW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store item
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/tsnd_front.sv @@
module tsnd_front
    import tsnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              last_char,
    output logic              job_valid,
    output note_job_t         job,
    input  logic              job_full
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LETTER = 3'd1;
    localparam logic [2:0] PH_OCTAVE = 3'd2;
    localparam logic [2:0] PH_COMMA  = 3'd3;
    localparam logic [2:0] PH_DUR    = 3'd4;

    logic [2:0]        phase_reg, phase_next;
    logic [CHAR_W-1:0] letter_reg, letter_next;
    logic [OCT_W-1:0]  oct_reg, oct_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [1:0]        pend_cnt_reg, pend_cnt_next;
    note_job_t         pend0_reg, pend0_next;
    note_job_t         pend1_reg, pend1_next;

    logic              accept;
    logic              dig;
    logic [OCT_W-1:0]  dval;
    logic [CHAR_W-1:0] folded;
    logic [DUR_W+3:0]  dur_wide;
    logic              done;
    logic [1:0]        n;
    note_job_t         j0, j1;

    assign accept    = push && !full;
    assign full      = pend_cnt_reg != 2'd0;
    assign job_valid = pend_cnt_reg != 2'd0;
    assign job       = pend0_reg;

    assign dig    = char_code >= CH_ZERO && char_code <= CH_NINE;
    assign dval   = OCT_W'(char_code - CH_ZERO);
    assign folded = (char_code >= CH_UP_A && char_code <= CH_UP_Z) ?
                    char_code + CH_CASE : char_code;

    // Parse one byte; emit up to two notes
    always_comb
    begin
        phase_next  = phase_reg;
        letter_next = letter_reg;
        oct_next    = oct_reg;
        dur_next    = dur_reg;
        done        = 1'b0;
        n           = 2'd0;
        j0          = '0;
        j1          = '0;
        dur_wide    = '0;
        if (phase_next > PH_DUR)
        begin
            phase_next = PH_IDLE;
        end
        if (phase_next == PH_IDLE)
        begin
            letter_next = folded;
            oct_next    = OCT_DEFAULT;
            dur_next    = DUR_DEFAULT;
            phase_next  = PH_LETTER;
            done        = 1'b1;
        end
        if (!done && phase_next == PH_LETTER)
        begin
            if (dig)
            begin
                oct_next = dval;
                done     = 1'b1;
            end
            phase_next = PH_OCTAVE;
        end
        if (!done && phase_next == PH_OCTAVE)
        begin
            if (char_code == CH_COMMA)
            begin
                done = 1'b1;
            end
            phase_next = PH_COMMA;
        end
        if (!done && phase_next == PH_COMMA)
        begin
            if (dig)
            begin
                dur_next = DUR_W'(dval);
                done     = 1'b1;
            end
            phase_next = PH_DUR;
        end
        if (!done && phase_next == PH_DUR)
        begin
            if (dig)
            begin
                dur_wide = {4'b0, dur_next} * (DUR_W+4)'(10) + (DUR_W+4)'(dval);
                dur_next = (dur_wide > DUR_MAX) ? DUR_MAX[DUR_W-1:0] : dur_wide[DUR_W-1:0];
            end
            else
            begin
                j0.tone = tone_of(letter_next, oct_next);
                j0.dur  = dur_next;
                n       = 2'd1;
                if (char_code == CH_SEMI)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    letter_next = folded;
                    oct_next    = OCT_DEFAULT;
                    dur_next    = DUR_DEFAULT;
                    phase_next  = PH_LETTER;
                end
            end
        end
        // Flush a pending note at string end
        if (last_char)
        begin
            if (phase_next != PH_IDLE)
            begin
                if (n == 2'd0)
                begin
                    j0.tone = tone_of(letter_next, oct_next);
                    j0.dur  = dur_next;
                end
                else
                begin
                    j1.tone = tone_of(letter_next, oct_next);
                    j1.dur  = dur_next;
                end
                n = n + 2'd1;
            end
            phase_next  = PH_IDLE;
            letter_next = '0;
            oct_next    = OCT_DEFAULT;
            dur_next    = DUR_DEFAULT;
        end
        // Mark the final note of this byte
        if (n == 2'd1)
        begin
            j0.last_of_run = 1'b1;
            j0.end_of_tune = last_char;
        end
        else if (n == 2'd2)
        begin
            j1.last_of_run = 1'b1;
            j1.end_of_tune = last_char;
        end
    end

    // Hold parsed notes and drain them one per cycle while the queue is not full
    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        pend0_next    = pend0_reg;
        pend1_next    = pend1_reg;
        if (accept)
        begin
            pend_cnt_next = n;
            pend0_next    = j0;
            pend1_next    = j1;
        end
        else if (job_valid && !job_full)
        begin
            pend_cnt_next = pend_cnt_reg - 2'd1;
            pend0_next    = pend1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            letter_reg   <= '0;
            oct_reg      <= OCT_DEFAULT;
            dur_reg      <= DUR_DEFAULT;
            pend_cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                letter_reg <= letter_next;
                oct_reg    <= oct_next;
                dur_reg    <= dur_next;
            end
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

endmodule

@@ rtl/tsnd_back.sv @@
module tsnd_back
    import tsnd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [BPM_W-1:0]   tempo,
    input  logic               job_empty,
    input  note_job_t          job,
    output logic               job_pop,
    output logic               empty,
    input  logic               pop,
    output logic [TONE_W-1:0]  tone_hz,
    output logic [PIT_W-1:0]   pit_divisor,
    output logic [DELAY_W-1:0] note_ms,
    output logic               is_rest,
    output logic               bad_duration,
    output logic               last_of_run,
    output logic               end_of_tune
);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_RUN1 = 2'd1;
    localparam logic [1:0] BK_RUN2 = 2'd2;
    localparam logic [1:0] BK_OUT  = 2'd3;

    logic [1:0]         st_reg, st_next;
    note_job_t          job_reg, job_next;
    logic [PIT_W-1:0]   pit_reg, pit_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic               out_valid_reg, out_valid_next;
    logic [TONE_W-1:0]  o_tone_reg;
    logic [PIT_W-1:0]   o_pit_reg;
    logic [DELAY_W-1:0] o_delay_reg;
    logic               o_rest_reg, o_bad_reg, o_last_reg, o_end_reg;

    div_req_t           req_a, req_b;
    logic               div_a_done, div_b_done;
    logic [DIV_NW-1:0]  quo_a, quo_b;
    logic               slot_free;
    logic               load_out;
    logic [BPM_W-1:0]   bpm;

    assign bpm       = (tempo == '0) ? BPM_W'(1) : tempo;
    assign slot_free = !out_valid_reg || pop;
    assign load_out  = (st_reg == BK_OUT) && slot_free;

    // Divider for the timer divisor
    tsnd_div u_div_a
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_a),
        .done     (div_a_done),
        .quotient (quo_a)
    );

    // Divider for tempo, then for duration
    tsnd_div u_div_b
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_b),
        .done     (div_b_done),
        .quotient (quo_b)
    );

    // Sequence one note through the dividers
    always_comb
    begin
        st_next    = st_reg;
        job_next   = job_reg;
        pit_next   = pit_reg;
        delay_next = delay_reg;
        job_pop    = 1'b0;
        req_a      = '0;
        req_b      = '0;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop        = 1'b1;
                    job_next       = job;
                    req_a.start    = 1'b1;
                    req_a.dividend = PIT_CLOCK;
                    req_a.divisor  = DIV_DW'(job.tone);
                    req_b.start    = 1'b1;
                    req_b.dividend = MS_PER_MIN;
                    req_b.divisor  = DIV_DW'(bpm);
                    st_next        = BK_RUN1;
                end
            end
            BK_RUN1:
            begin
                if (div_a_done)
                begin
                    pit_next = (job_reg.tone == '0) ? '0 : quo_a[PIT_W-1:0];
                    if (job_reg.dur == '0)
                    begin
                        delay_next = '0;
                        st_next    = BK_OUT;
                    end
                    else
                    begin
                        req_b.start    = 1'b1;
                        req_b.dividend = {quo_b[DIV_NW-3:0], 2'b00};
                        req_b.divisor  = DIV_DW'(job_reg.dur);
                        st_next        = BK_RUN2;
                    end
                end
            end
            BK_RUN2:
            begin
                if (div_b_done)
                begin
                    delay_next = quo_b[DELAY_W-1:0];
                    st_next    = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (slot_free)
                begin
                    st_next = BK_IDLE;
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    // Output register: set on load, drop on pop
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        pit_reg   <= pit_next;
        delay_reg <= delay_next;
        if (load_out)
        begin
            o_tone_reg  <= job_reg.tone;
            o_pit_reg   <= pit_reg;
            o_delay_reg <= delay_reg;
            o_rest_reg  <= job_reg.tone == '0;
            o_bad_reg   <= job_reg.dur == '0;
            o_last_reg  <= job_reg.last_of_run;
            o_end_reg   <= job_reg.end_of_tune;
        end
    end

    assign empty        = !out_valid_reg;
    assign tone_hz      = o_tone_reg;
    assign pit_divisor  = o_pit_reg;
    assign note_ms      = o_delay_reg;
    assign is_rest      = o_rest_reg;
    assign bad_duration = o_bad_reg;
    assign last_of_run  = o_last_reg;
    assign end_of_tune  = o_end_reg;

    // Divisor unit finishes only while its note is still in the first pass
    a_div_a_in_run1: assert property (@(posedge clk) disable iff (!rst_n)
        div_a_done |-> st_reg == BK_RUN1)
        else $error("timer divider finished outside first pass");

    // Both dividers start together from idle, so the timer divider finishes with the other
    a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
        div_a_done |-> div_b_done)
        else $error("tempo divider out of step with timer divider");

    // Second divider pass only for a nonzero duration
    a_run2_dur: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == BK_RUN2 |-> job_reg.dur != '0)
        else $error("duration divide started on zero duration");

    // A load fills the output register
    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && st_reg == BK_IDLE)
        else $error("result load lost");

endmodule
